FILE: src/fhsc_pkg.sv
// File header signature classifier: shared constants, signature tables, types.
// Used by every module of the block; depends on nothing.
package fhsc_pkg;

    // Number of leading bytes that take part in classification
    localparam int unsigned HEADER_BYTES = 32;
    // Byte counter holds 0..HEADER_BYTES
    localparam int unsigned CNT_W        = $clog2(HEADER_BYTES + 1);

    localparam int unsigned NUM_SIGS     = 15;
    localparam int unsigned SIG_MAX_LEN  = 9;
    localparam int unsigned POS_W        = $clog2(SIG_MAX_LEN);
    localparam int unsigned LEN_W        = $clog2(SIG_MAX_LEN + 1);

    // Result type codes
    localparam logic [3:0] TYPE_NONE   = 4'd0;
    localparam logic [3:0] TYPE_JPEG   = 4'd1;
    localparam logic [3:0] TYPE_PNG    = 4'd2;
    localparam logic [3:0] TYPE_GIF    = 4'd3;
    localparam logic [3:0] TYPE_ZIP    = 4'd4;
    localparam logic [3:0] TYPE_PDF    = 4'd5;
    localparam logic [3:0] TYPE_HTML   = 4'd6;
    localparam logic [3:0] TYPE_GZIP   = 4'd7;
    localparam logic [3:0] TYPE_BZIP2  = 4'd8;
    localparam logic [3:0] TYPE_ELF    = 4'd9;
    localparam logic [3:0] TYPE_DOSEXE = 4'd10;
    localparam logic [3:0] TYPE_TEXT   = 4'd11;
    localparam logic [3:0] TYPE_BINARY = 4'd12;

    // Signature table, in priority order
    localparam logic [LEN_W-1:0] SIG_LEN [NUM_SIGS] = '{
        LEN_W'(3), LEN_W'(8), LEN_W'(6), LEN_W'(6), LEN_W'(4),
        LEN_W'(4), LEN_W'(4), LEN_W'(4), LEN_W'(9), LEN_W'(5),
        LEN_W'(5), LEN_W'(2), LEN_W'(3), LEN_W'(4), LEN_W'(2)
    };

    localparam logic [3:0] SIG_CODE [NUM_SIGS] = '{
        TYPE_JPEG, TYPE_PNG, TYPE_GIF, TYPE_GIF, TYPE_ZIP,
        TYPE_ZIP, TYPE_ZIP, TYPE_PDF, TYPE_HTML, TYPE_HTML,
        TYPE_HTML, TYPE_GZIP, TYPE_BZIP2, TYPE_ELF, TYPE_DOSEXE
    };

    // Unused tail positions are zero and never compared
    localparam logic [7:0] SIG_PAT [NUM_SIGS][SIG_MAX_LEN] = '{
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h07, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45},
        '{8'h3C, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 8'h48, 8'h54, 8'h4D, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Running state of one file, after the current byte
    typedef struct packed {
        logic [CNT_W-1:0]    bytes_seen;
        logic [NUM_SIGS-1:0] signature_alive;
        logic                all_printable;
    } t_track_state;

    // Tab, LF, FF, CR, or 32..127
    function automatic logic byte_is_printable(input logic [7:0] b);
        logic in_range;
        in_range = (b >= 8'd32) && (b <= 8'd127);
        return in_range || (b == 8'd9) || (b == 8'd10) || (b == 8'd12) || (b == 8'd13);
    endfunction

endpackage

FILE: src/fhsc_in_if.sv
// Input channel of the file header signature classifier: one header byte per item.
// Depends on nothing.
interface fhsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/fhsc_out_if.sv
// Output channel of the file header signature classifier: one type code per item.
// Depends on nothing.
interface fhsc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] type_code;

    modport source (output valid, output type_code, input ready);
    modport sink   (input valid, input type_code, output ready);
endinterface

FILE: src/fhsc_tracker.sv
// Per-file running state: byte count, signature match flags, printable flag.
// Depends on fhsc_pkg.
module fhsc_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output fhsc_pkg::t_track_state o_next
);
    import fhsc_pkg::*;

    t_track_state r_state;
    t_track_state n_state;
    logic         counting;
    logic [POS_W-1:0] pos;

    // Fold the current byte into the running state
    always_comb begin
        counting = r_state.bytes_seen < CNT_W'(HEADER_BYTES);
        pos      = (r_state.bytes_seen < CNT_W'(SIG_MAX_LEN))
                   ? r_state.bytes_seen[POS_W-1:0] : '0;
        n_state  = r_state;
        if (counting) begin
            for (int i = 0; i < NUM_SIGS; i++) begin
                if ((r_state.bytes_seen < CNT_W'(SIG_LEN[i])) &&
                    (SIG_PAT[i][pos] != i_data_byte)) begin
                    n_state.signature_alive[i] = 1'b0;
                end
            end
            if (!byte_is_printable(i_data_byte)) begin
                n_state.all_printable = 1'b0;
            end
            n_state.bytes_seen = r_state.bytes_seen + CNT_W'(1);
        end
    end

    assign o_next = n_state;

    // State register; back to reset values after the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.bytes_seen      <= '0;
            r_state.signature_alive <= '1;
            r_state.all_printable   <= 1'b1;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_state.bytes_seen      <= '0;
                r_state.signature_alive <= '1;
                r_state.all_printable   <= 1'b1;
            end else begin
                r_state <= n_state;
            end
        end
    end

endmodule

FILE: src/fhsc_classify.sv
// Picks the type code from the state after the last byte of a file.
// Depends on fhsc_pkg.
module fhsc_classify (
    input  fhsc_pkg::t_track_state i_state,
    output logic [3:0]             o_type_code
);
    import fhsc_pkg::*;

    logic found;

    // First live signature that fits in the counted bytes wins
    always_comb begin
        found       = 1'b0;
        o_type_code = i_state.all_printable ? TYPE_TEXT : TYPE_BINARY;
        for (int i = 0; i < NUM_SIGS; i++) begin
            if (!found && i_state.signature_alive[i] &&
                (i_state.bytes_seen >= CNT_W'(SIG_LEN[i]))) begin
                found       = 1'b1;
                o_type_code = SIG_CODE[i];
            end
        end
        if (i_state.bytes_seen < CNT_W'(2)) begin
            o_type_code = TYPE_NONE;
        end
    end

endmodule

FILE: src/file_header_signature_classifier.sv
// File header signature classifier, top level: input register, tracker,
// classifier and result register. Depends on fhsc_pkg, fhsc_in_if, fhsc_out_if.
//
// Usage:
//   i_in carries the leading bytes of a file, one per item, from offset zero;
//   last_byte marks the final byte of the file. Only the first HEADER_BYTES
//   bytes count, later ones are dropped but a last marker on them still counts.
//   o_out carries one type code per file, produced by the item with last_byte.
//   Throughput: one byte per cycle, sustained, with a free output side.
//   Result path: the last byte sits in the input register while the match and
//   classify logic feeds the result register, which then presents the type
//   code.
//   A stalled result holds in the result register; bytes that do not end a
//   file keep flowing past it, and the next last byte waits in the input
//   register, lowering i_in.ready, until the result is taken.
//   Reset (synchronous, active low) empties both registers, clears the byte
//   count and match flags, and holds i_in.ready low while asserted.
module file_header_signature_classifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fhsc_in_if.sink       i_in,
    fhsc_out_if.source    o_out
);
    import fhsc_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    logic [3:0]   r_out_code;
    logic         out_free;
    logic         advance;
    t_track_state next_state;
    logic [3:0]   type_code;

    // Handshake: a byte moves on unless it ends a file and the result is held
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = i_rst_n && (!r_in_valid || advance);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    fhsc_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_next      (next_state)
    );

    fhsc_classify u_classify (
        .i_state     (next_state),
        .o_type_code (type_code)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_code <= type_code;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.type_code = r_out_code;

endmodule

FILE: src/fhsc_checker.sv
// Port-level checks for the file header signature classifier, bound to the top level.
// Depends on fhsc_pkg.
module fhsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last_byte,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_type_code
);
    import fhsc_pkg::*;

    // Reset empties the result register and blocks input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_reset_no_accept: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_in_ready)
        else $error("input ready during reset");

    // A fresh result must trace back to an accepted last byte
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last_byte, 2))
        else $error("result without a last byte");

    // Type code stays within the defined codes
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_type_code <= TYPE_BINARY))
        else $error("undefined type code");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_type_code))
        else $error("stalled result changed");

endmodule

bind file_header_signature_classifier fhsc_checker u_fhsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_last_byte  (i_in.last_byte),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_type_code (o_out.type_code)
);

FILE: tb/sv/file_header_signature_classifier_tb.sv
// Testbench for the file header signature classifier: streams file headers byte by byte,
// predicts each type code and checks it in order. Depends on fhsc_pkg, fhsc_in_if,
// fhsc_out_if and the file_header_signature_classifier RTL.

import fhsc_pkg::*;

// Type code predictor plus the queue of type codes still owed by the block
class file_type_scoreboard;
    logic [71:0]  sig_pat  [15];   // signature bytes, left aligned, offset zero first
    int unsigned  sig_len  [15];
    logic [3:0]   sig_type [15];
    int unsigned  hdr_count;
    logic [14:0]  sig_alive;
    bit           all_text;
    logic [3:0]   expected_types [$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  type_hits [16];

    function new();
        // priority order: first live, fully seen signature wins
        add_sig(0,  3, TYPE_JPEG,   72'hFFD8FF000000000000);
        add_sig(1,  8, TYPE_PNG,    72'h89504E470D0A1A0A00);
        add_sig(2,  6, TYPE_GIF,    72'h474946383761000000);
        add_sig(3,  6, TYPE_GIF,    72'h474946383961000000);
        add_sig(4,  4, TYPE_ZIP,    72'h504B03040000000000);
        add_sig(5,  4, TYPE_ZIP,    72'h504B05060000000000);
        add_sig(6,  4, TYPE_ZIP,    72'h504B07080000000000);
        add_sig(7,  4, TYPE_PDF,    72'h255044460000000000);
        add_sig(8,  9, TYPE_HTML,   72'h3C21444F4354595045);
        add_sig(9,  5, TYPE_HTML,   72'h3C68746D6C00000000);
        add_sig(10, 5, TYPE_HTML,   72'h3C48544D4C00000000);
        add_sig(11, 2, TYPE_GZIP,   72'h1F8B00000000000000);
        add_sig(12, 3, TYPE_BZIP2,  72'h425A68000000000000);
        add_sig(13, 4, TYPE_ELF,    72'h7F454C460000000000);
        add_sig(14, 2, TYPE_DOSEXE, 72'h4D5A00000000000000);
        clear_file();
        mismatches      = 0;
        results_checked = 0;
        foreach (type_hits[i]) type_hits[i] = 0;
    endfunction

    function void add_sig(int i, int unsigned n, logic [3:0] code, logic [71:0] pat);
        sig_len[i]  = n;
        sig_type[i] = code;
        sig_pat[i]  = pat;
    endfunction

    function logic [7:0] sig_byte(int i, int unsigned pos);
        return sig_pat[i][71 - 8*pos -: 8];
    endfunction

    function void clear_file();
        hdr_count = 0;
        sig_alive = '1;
        all_text  = 1'b1;
    endfunction

    // Tab, LF, FF, CR or plain 7-bit printable
    function bit text_char(logic [7:0] b);
        case (b)
            8'h09, 8'h0A, 8'h0C, 8'h0D: return 1'b1;
            default:                    return (b >= 8'h20) && (b < 8'h80);
        endcase
    endfunction

    function logic [3:0] file_type();
        if (hdr_count < 2) return TYPE_NONE;
        for (int i = 0; i < 15; i++)
            if (sig_alive[i] && hdr_count >= sig_len[i]) return sig_type[i];
        return all_text ? TYPE_TEXT : TYPE_BINARY;
    endfunction

    // Called for each accepted input item
    function void note_byte(logic [7:0] b, logic last);
        if (hdr_count < HEADER_BYTES) begin
            for (int i = 0; i < 15; i++)
                if (hdr_count < sig_len[i] && sig_byte(i, hdr_count) != b) sig_alive[i] = 1'b0;
            if (!text_char(b)) all_text = 1'b0;
            hdr_count++;
        end
        if (last) begin
            expected_types = {expected_types, file_type()};
            clear_file();
        end
    endfunction

    // Called for each accepted result item
    function void check_type(logic [3:0] actual);
        logic [3:0] want;
        if (expected_types.size() == 0) begin
            $display("%0t: unexpected type code %0d with nothing outstanding", $time, actual);
            mismatches++;
            return;
        end
        want = expected_types.pop_front();
        results_checked++;
        type_hits[want]++;
        if (actual !== want) begin
            $display("%0t: type code mismatch: expected %0d, actual %0d", $time, want, actual);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_types.size();
    endfunction
endclass

module file_header_signature_classifier_tb;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RANDOM_BYTES = 1310;
    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [7:0]  CH_FF  = 8'h0C;
    localparam logic [7:0]  CH_CR  = 8'h0D;

    logic                i_clk;
    logic                i_rst_n;
    fhsc_in_if           in_ch ();
    fhsc_out_if          out_ch ();
    file_type_scoreboard sb;
    bit                  no_idle;
    int unsigned         bytes_sent;
    int unsigned         files_sent;
    int unsigned         cycles = 0;

    file_header_signature_classifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Mostly no gap, some short, a few long; none during a burst stretch
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return CH_TAB;
                1:       return CH_LF;
                2:       return CH_FF;
                default: return CH_CR;
            endcase
        end
        return 8'($urandom_range(32, 127));
    endfunction

    function automatic void add_signature(ref logic [7:0] q [$], input int s,
                                          input int unsigned n);
        for (int unsigned k = 0; k < n; k++) q = {q, sb.sig_byte(s, k)};
    endfunction

    // One byte item; returns at a falling edge with the optional gap done
    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
        gap = idle_cycles();
        if (gap != 0) begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            in_ch.last_byte <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_file(logic [7:0] hdr [$]);
        foreach (hdr[k]) send_byte(hdr[k], k == hdr.size() - 1);
        files_sent++;
    endtask

    // Hold the input side until every owed type code has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic run_directed();
        logic [7:0] q [$];
        // every signature exactly, nothing after it
        for (int s = 0; s < 15; s++) begin
            q = {};
            add_signature(q, s, sb.sig_len[s]);
            send_file(q);
        end
        // single byte: too short to classify
        q = {8'hFF};
        send_file(q);
        // two bytes at the field extremes
        q = {8'h00, 8'hFF};
        send_file(q);
        // doctype cut short: signature longer than the data, falls to text
        q = {};
        add_signature(q, 8, 5);
        send_file(q);
        // every text control plus both ends of the printable range
        q = {CH_TAB, CH_LF, CH_FF, CH_CR, 8'h20, 8'h7E, 8'h7F};
        send_file(q);
        // just outside the printable set
        q = {8'h41, 8'h80};
        send_file(q);
        q = {8'h41, 8'h1F, 8'h0B, 8'h08};
        send_file(q);
        // last signature byte wrong
        q = {8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h62};
        send_file(q);
        // text header, binary junk past the header window, last marker on the junk
        q = {};
        while (q.size() < HEADER_BYTES) q = {q, text_byte()};
        repeat (8) q = {q, 8'h00};
        q = {q, 8'hFF};
        send_file(q);
    endtask

    task automatic run_random();
        logic [7:0]  q [$];
        int unsigned kind;
        int unsigned n;
        int unsigned cut;
        int          s;
        int unsigned stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            q    = {};
            kind = $urandom_range(0, 99);
            s    = $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
            if (kind < 45) begin
                // well-formed signature with random trailing content
                add_signature(q, s, sb.sig_len[s]);
                n = $urandom_range(0, 10);
                repeat (n) q = {q, ($urandom_range(0, 1) ? text_byte() : 8'($urandom))};
            end else if (kind < 60) begin
                // signature truncated or broken by one flipped bit
                cut = $urandom_range(1, sb.sig_len[s]);
                add_signature(q, s, cut - 1);
                if ($urandom_range(0, 2) != 0)
                    q = {q, (sb.sig_byte(s, cut - 1) ^ 8'(1 << $urandom_range(0, 7)))};
                n = $urandom_range(0, 6);
                repeat (n) q = {q, text_byte()};
            end else if (kind < 75) begin
                n = $urandom_range(2, 24);
                repeat (n) q = {q, text_byte()};
            end else if (kind < 85) begin
                n = $urandom_range(1, 24);
                repeat (n) q = {q, 8'($urandom)};
            end else if (kind < 93) begin
                // longer than the header window; tail bytes must not matter
                n = $urandom_range(HEADER_BYTES + 1, HEADER_BYTES + 28);
                if ($urandom_range(0, 1) != 0) add_signature(q, s, sb.sig_len[s]);
                while (q.size() < HEADER_BYTES)
                    q = {q, (($urandom_range(0, 7) == 0) ? 8'($urandom) : text_byte())};
                while (q.size() < n) q = {q, 8'($urandom)};
            end else begin
                n = $urandom_range(1, 2);
                repeat (n) q = {q, 8'($urandom)};
            end
            if (q.size() == 0) q = {q, 8'($urandom)};
            send_file(q);
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    // Stimulus and end of run
    initial begin
        string per_type;
        sb                = new();
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'h00;
        in_ch.last_byte   = 1'b0;
        no_idle           = 1'b0;
        bytes_sent        = 0;
        files_sent        = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (8) @(posedge i_clk);
        per_type = "";
        for (int t = 0; t <= 12; t++) per_type = {per_type, $sformatf(" %0d", sb.type_hits[t])};
        $display("Streamed %0d files in %0d header bytes, %0d type codes checked.",
                 files_sent, bytes_sent, sb.results_checked);
        $display("Files per type code, none through binary:%s", per_type);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls of varied length
    initial begin : result_sink
        int unsigned stall;
        stall        = 0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall != 0) begin
                stall--;
                if (stall == 0) out_ch.ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                out_ch.ready <= 1'b0;
                stall = 1 + idle_cycles();
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_type(out_ch.type_code);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run timed out, %0d type codes outstanding", $time, sb.outstanding());
            $display("FAIL");
            $finish;
        end
    end

endmodule

FILE: sim.f
src/fhsc_pkg.sv
src/fhsc_in_if.sv
src/fhsc_out_if.sv
src/fhsc_tracker.sv
src/fhsc_classify.sv
src/file_header_signature_classifier.sv
src/fhsc_checker.sv
tb/sv/file_header_signature_classifier_tb.sv
